// ----- rtl/assert_macros.svh -----
// assertion macros shared by the selection block
// no dependencies; the checks vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define USPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every clock edge, reset included
`define USPS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define USPS_ASSERT(lbl, prop, msg)
`define USPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/usps_pkg.sv -----
// shared types, widths and register codes of the parent selection block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package usps_pkg;

   localparam int MAX_POPULATION_DEF = 64;

   localparam int FIT_W       = 32;
   localparam int TOTAL_W     = 40;
   localparam int ACC_W       = 56;
   localparam int COUNT_W     = 7;
   localparam int IDX_FIELD_W = 6;
   localparam int TARGET_W    = 7;
   localparam int PRESERVE_W  = 7;
   localparam int SHARE_W     = 9;
   localparam int STEP_W      = TOTAL_W + SHARE_W;
   localparam int SCALE_SHIFT = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int RSP_Q_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POPULATION_TARGET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESERVED_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEST_SHARE        = 2'd2;

   localparam logic [TARGET_W-1:0]   TARGET_RESET   = 7'd64;
   localparam logic [PRESERVE_W-1:0] PRESERVE_RESET = 7'd0;
   localparam logic [SHARE_W-1:0]    SHARE_RESET    = 9'd256;

   localparam logic KIND_PRESERVED = 1'b0;
   localparam logic KIND_SAMPLED   = 1'b1;

   typedef logic [IDX_FIELD_W-1:0] idx_field_type;

   typedef struct packed {
      logic signed [FIT_W-1:0] fitness;
      logic                    last_item;
   } req_type;

   typedef struct packed {
      logic          kind;
      idx_field_type parent_index;
      logic          last_result;
   } rsp_type;

   typedef struct packed {
      logic [TARGET_W-1:0]   population_target;
      logic [PRESERVE_W-1:0] preserved_count;
      logic [SHARE_W-1:0]    best_share;
   } cfg_type;

   // one closed load handed from the loader to the walker
   typedef struct packed {
      logic [COUNT_W-1:0]      loaded;
      logic signed [FIT_W-1:0] lowest;
      logic [TOTAL_W-1:0]      total;
   } run_type;

   typedef struct packed {
      logic               en;
      idx_field_type      addr;
      logic [FIT_W-1:0]   data;
   } store_wr_type;

endpackage
`default_nettype wire

// ----- rtl/usps_front.sv -----
// loader: takes fitness words, keeps the minimum and shifted total, hands off a run
// depends on usps_pkg
`timescale 1ns / 1ps
`default_nettype none
module usps_front #(
   parameter int MAX_POPULATION = usps_pkg::MAX_POPULATION_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  usps_pkg::req_type      req_data,
   output logic                   full,
   input  wire                    walk_busy,
   input  wire                    run_take,
   output logic                   run_valid,
   output usps_pkg::run_type      run_data,
   output usps_pkg::store_wr_type store_wr
);
   import usps_pkg::*;

   localparam int CNT_W = $clog2(MAX_POPULATION + 1);
   localparam int IDX_W = $clog2(MAX_POPULATION);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [FIT_W-1:0] lowest_ff, lowest_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic                    run_valid_ff;
   run_type                 run_ff;

   logic                    accept;
   logic                    room;
   logic signed [FIT_W-1:0] fit;
   logic                    below;
   logic [FIT_W:0]          gap;
   logic [FIT_W:0]          rise;
   logic [FIT_W+CNT_W:0]    rebase;
   logic [TOTAL_W-1:0]      add_term;

   assign fit    = req_data.fitness;
   assign full   = run_valid_ff | walk_busy;
   assign accept = push & ~full;
   assign room   = count_ff < CNT_W'(MAX_POPULATION);
   assign below  = fit < lowest_ff;

   // a new minimum rebases every stored value by the drop
   assign gap      = {lowest_ff[FIT_W-1], lowest_ff} - {fit[FIT_W-1], fit};
   assign rise     = {fit[FIT_W-1], fit} - {lowest_ff[FIT_W-1], lowest_ff};
   assign rebase   = gap * count_ff;
   assign add_term = below ? TOTAL_W'(rebase) : TOTAL_W'(rise);

   always_comb begin
      count_in  = count_ff;
      lowest_in = lowest_ff;
      total_in  = total_ff;
      if (room) begin
         count_in = count_ff + CNT_W'(1);
         total_in = total_ff + add_term;
         if (below) begin
            lowest_in = fit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lowest_ff    <= '0;
         total_ff     <= '0;
         run_valid_ff <= 1'b0;
      end else begin
         if (run_take) begin
            run_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (req_data.last_item) begin
               count_ff     <= '0;
               lowest_ff    <= '0;
               total_ff     <= '0;
               run_valid_ff <= 1'b1;
            end else begin
               count_ff  <= count_in;
               lowest_ff <= lowest_in;
               total_ff  <= total_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.last_item) begin
         run_ff.loaded <= COUNT_W'(count_in);
         run_ff.lowest <= lowest_in;
         run_ff.total  <= total_in;
      end
   end

   assign run_valid = run_valid_ff;
   assign run_data  = run_ff;

   assign store_wr.en   = accept & room;
   assign store_wr.addr = idx_field_type'(count_ff[IDX_W-1:0]);
   assign store_wr.data = fit;

endmodule
`default_nettype wire

// ----- rtl/usps_walk.sv -----
// walker: fitness store, preserved pass and sampling walk over the running sum
// depends on usps_pkg
`timescale 1ns / 1ps
`default_nettype none
module usps_walk #(
   parameter int MAX_POPULATION = usps_pkg::MAX_POPULATION_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  usps_pkg::cfg_type      cfg,
   input  usps_pkg::store_wr_type store_wr,
   input  wire                    run_valid,
   input  usps_pkg::run_type      run_data,
   output logic                   run_take,
   output logic                   walk_busy,
   input  wire                    q_full,
   output logic                   q_push,
   output usps_pkg::rsp_type      q_data
);
   import usps_pkg::*;

   localparam int CNT_W = $clog2(MAX_POPULATION + 1);
   localparam int IDX_W = $clog2(MAX_POPULATION);
   localparam int PROD_W = FIT_W + CNT_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_PRES  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_ADD   = 3'd5;
   localparam logic [2:0] ST_CMP   = 3'd6;
   localparam logic [2:0] ST_FLUSH = 3'd7;

   logic [FIT_W-1:0] store_mem [MAX_POPULATION];
   logic [FIT_W-1:0] rd_ff;

   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic signed [FIT_W-1:0] lowest_ff, lowest_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]        p_ff, p_in;
   logic [CNT_W-1:0]        children_ff, children_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [ACC_W-1:0]        lhs_ff, lhs_in;
   logic [ACC_W-1:0]        rhs_ff, rhs_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    pend_valid_ff, pend_valid_in;
   rsp_type                 pend_ff, pend_in;

   logic             emit;
   logic             emit_kind;
   logic             emit_ok;
   logic [CNT_W-1:0] p_w;
   logic [CNT_W-1:0] target_w;
   logic [CNT_W-1:0] children_w;
   logic [CNT_W-1:0] idx_next;
   logic [FIT_W:0]   lift;

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr[IDX_W-1:0]] <= store_wr.data;
      end
      rd_ff <= store_mem[idx_ff[IDX_W-1:0]];
   end

   assign p_w = (cfg.preserved_count < PRESERVE_W'(n_ff)) ?
                CNT_W'(cfg.preserved_count) : n_ff;
   assign target_w = (cfg.population_target > TARGET_W'(MAX_POPULATION)) ?
                     CNT_W'(MAX_POPULATION) : CNT_W'(cfg.population_target);
   assign children_w = (target_w > p_w) ? target_w - p_w : '0;
   assign idx_next   = idx_ff + CNT_W'(1);
   assign lift       = {rd_ff[FIT_W-1], rd_ff} - {lowest_ff[FIT_W-1], lowest_ff};
   assign emit_ok    = ~pend_valid_ff | ~q_full;
   assign walk_busy  = state_ff != ST_IDLE;

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      lowest_in     = lowest_ff;
      total_in      = total_ff;
      p_in          = p_ff;
      children_in   = children_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      lhs_in        = lhs_ff;
      rhs_in        = rhs_ff;
      prod_in       = prod_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      run_take      = 1'b0;
      emit          = 1'b0;
      emit_kind     = KIND_PRESERVED;
      q_push        = 1'b0;
      q_data        = pend_ff;
      q_data.last_result = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (run_valid) begin
               run_take  = 1'b1;
               n_in      = CNT_W'(run_data.loaded);
               lowest_in = run_data.lowest;
               total_in  = run_data.total;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            p_in        = p_w;
            children_in = children_w;
            step_in     = total_ff * cfg.best_share;
            idx_in      = '0;
            state_in    = ST_PRES;
         end
         ST_PRES: begin
            if (idx_ff < p_ff) begin
               emit      = 1'b1;
               emit_kind = KIND_PRESERVED;
               if (emit_ok) begin
                  idx_in = idx_next;
               end
            end else begin
               idx_in = '0;
               cnt_in = '0;
               lhs_in = ACC_W'(step_ff);
               rhs_in = '0;
               if (children_ff != '0 && cfg.best_share != '0) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = lift[FIT_W-1:0] * children_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            rhs_in   = rhs_ff + (ACC_W'(prod_ff) << SCALE_SHIFT);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (cnt_ff < children_ff && lhs_ff <= rhs_ff) begin
               emit      = 1'b1;
               emit_kind = KIND_SAMPLED;
               if (emit_ok) begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  lhs_in = lhs_ff + ACC_W'(step_ff);
               end
            end else if (idx_next < n_ff && cnt_ff < children_ff) begin
               idx_in   = idx_next;
               state_in = ST_READ;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               if (!q_full) begin
                  q_push             = 1'b1;
                  q_data.last_result = 1'b1;
                  pend_valid_in      = 1'b0;
                  state_in           = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // the held word goes out once the next one exists, so the final one can be marked
      if (emit && emit_ok) begin
         if (pend_valid_ff) begin
            q_push = 1'b1;
         end
         pend_in.kind         = emit_kind;
         pend_in.parent_index = idx_field_type'(idx_ff);
         pend_in.last_result  = 1'b0;
         pend_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      lowest_ff   <= lowest_in;
      total_ff    <= total_in;
      p_ff        <= p_in;
      children_ff <= children_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
      prod_ff     <= prod_in;
      pend_ff     <= pend_in;
   end

endmodule
`default_nettype wire

// ----- rtl/usps_rsp_q.sv -----
// result queue: short fifo between the walker and the result port
// depends on usps_pkg
`timescale 1ns / 1ps
`default_nettype none
module usps_rsp_q (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  usps_pkg::rsp_type  push_data,
   output logic               full,
   input  wire                pop,
   output logic               empty,
   output usps_pkg::rsp_type  pop_data
);
   import usps_pkg::*;

   localparam int PTR_W = $clog2(RSP_Q_DEPTH);
   localparam int LVL_W = $clog2(RSP_Q_DEPTH + 1);

   rsp_type            slot_ff [RSP_Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [LVL_W-1:0]   level_ff;
   logic               do_push;
   logic               do_pop;

   assign full     = level_ff == LVL_W'(RSP_Q_DEPTH);
   assign empty    = level_ff == '0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(RSP_Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(RSP_Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            level_ff <= level_ff + LVL_W'(1);
         end else if (do_pop && !do_push) begin
            level_ff <= level_ff - LVL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/universal_sampling_parent_select.sv -----
// Parent selection by stochastic universal sampling. A generation is loaded as
// fitness words (signed Q16.16, best first) through push/full, one word per cycle
// while full is low; the word with last_item set closes the load. Up to
// MAX_POPULATION words are stored, later ones are dropped but a dropped closing
// word still starts the run. The block then emits kept parents (kind 0, indices
// 0 .. min(preserved_count, stored)-1) and sampled parents (kind 1) up to
// population_target, the final word of the run flagged by last_result; results are
// read through empty/pop. While the walker runs, full stays high because it reads
// the fitness store. A run sets up, emits the kept parents, then walks each
// individual (store read, multiply, add, compare), repeating the compare per sampled
// parent, and closes with a flush. The user must write the configuration registers
// through valid/ready only while no run is open; the block does not enforce this.
// depends on usps_pkg, usps_front, usps_walk, usps_rsp_q and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module universal_sampling_parent_select #(
   parameter int MAX_POPULATION = usps_pkg::MAX_POPULATION_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // load side
   input  wire                                    push,
   input  usps_pkg::req_type                      req_data,
   output logic                                   full,
   // result side
   input  wire                                    pop,
   output logic                                   empty,
   output usps_pkg::rsp_type                      rsp_data,
   // register writes
   input  wire                                    valid,
   output logic                                   ready,
   input  wire [usps_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire [usps_pkg::CSR_DATA_W-1:0]         csr_data
);
   import usps_pkg::*;

   // register values right after reset
   localparam cfg_type CFG_RESET = '{TARGET_RESET, PRESERVE_RESET, SHARE_RESET};

   // configuration registers
   logic [TARGET_W-1:0]   target_ff;
   logic [PRESERVE_W-1:0] preserve_ff;
   logic [SHARE_W-1:0]    share_ff;
   cfg_type               cfg;

   // loader to walker handoff
   run_type      run_data;
   logic         run_valid;
   logic         run_take;
   logic         walk_busy;
   store_wr_type store_wr;

   // walker to result queue
   logic    rsp_push;
   rsp_type rsp_push_data;
   logic    rsp_full;

   // writes are always taken
   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_RESET;
         preserve_ff <= PRESERVE_RESET;
         share_ff    <= SHARE_RESET;
      end else if (valid) begin
         case (csr_index)
            CSR_POPULATION_TARGET: begin
               target_ff <= csr_data[TARGET_W-1:0];
            end
            CSR_PRESERVED_COUNT: begin
               preserve_ff <= csr_data[PRESERVE_W-1:0];
            end
            CSR_BEST_SHARE: begin
               share_ff <= csr_data[SHARE_W-1:0];
            end
            default: begin
               // unmapped index, word ignored
            end
         endcase
      end
   end

   assign cfg.population_target = target_ff;
   assign cfg.preserved_count   = preserve_ff;
   assign cfg.best_share        = share_ff;

   // front: sends each word that fits to the walker's store and tracks minimum and shifted total
   usps_front #(
      .MAX_POPULATION (MAX_POPULATION)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .walk_busy (walk_busy),
      .run_take  (run_take),
      .run_valid (run_valid),
      .run_data  (run_data),
      .store_wr  (store_wr)
   );

   // back: kept parents, then the evenly spaced pointer walk
   usps_walk #(
      .MAX_POPULATION (MAX_POPULATION)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .store_wr  (store_wr),
      .run_valid (run_valid),
      .run_data  (run_data),
      .run_take  (run_take),
      .walk_busy (walk_busy),
      .q_full    (rsp_full),
      .q_push    (rsp_push),
      .q_data    (rsp_push_data)
   );

   // result words wait here until popped
   usps_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .full      (rsp_full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (rsp_data)
   );

   // the store must not take new words while the walker still reads it
   `USPS_ASSERT(a_walk_holds_load, walk_busy |-> full, "load accepted during walk")
   // a closing word always stops the load until the run is handed off
   `USPS_ASSERT(a_last_word_stalls, (push & ~full & req_data.last_item) |=> full, "missing stall")
   // the walker only pushes when the result queue has room
   `USPS_ASSERT(a_rsp_q_no_overflow, rsp_push |-> !rsp_full, "result queue overflow")
   // registers come out of reset at their defaults
   `USPS_ASSERT_ALWAYS(a_csr_reset_values, reset |=> (cfg == CFG_RESET), "register reset value")

endmodule
`default_nettype wire

// ----- tb/sv/universal_sampling_parent_select_test.sv -----
// self-checking testbench for the stochastic universal sampling parent selector
// depends on usps_pkg and the rtl top universal_sampling_parent_select
`timescale 1ns / 1ps
module universal_sampling_parent_select_test;
   import usps_pkg::*;

   localparam int MAX_POP = MAX_POPULATION_DEF;
   // longest walk: setup, every kept parent, store read, multiply, add and compare per individual, every child
   localparam int WALK_LATENCY = 420;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS = 80;
   localparam int N_DIRECTED = 19;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     push = 1'b0;
   req_type  req_data = '0;
   logic     full;
   logic     pop = 1'b0;
   logic     empty;
   rsp_type  rsp_data;
   logic     valid = 1'b0;
   logic     ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_POPULATION_TARGET;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   always #10 clock = ~clock;

   universal_sampling_parent_select dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------------
   // selection predictor: own copy of the load state and the registers
   // ---------------------------------------------------------------------------
   logic signed [FIT_W-1:0] fit_mem [MAX_POP];
   int unsigned             n_loaded = 0;
   longint                  lowest = 0;     // min of zero and every stored fitness
   bit [63:0]               total = '0;     // sum of fitness - lowest over the load
   logic [TARGET_W-1:0]     cfg_target = TARGET_RESET;
   logic [PRESERVE_W-1:0]   cfg_keep = PRESERVE_RESET;
   logic [SHARE_W-1:0]      cfg_share = SHARE_RESET;

   rsp_type picks[$];              // parents chosen by the latest word
   rsp_type expected_parents[$];   // parents still to come out of the block

   // one accepted word: store it, and on the closing word run the selection
   function automatic void load_word(input req_type w);
      longint      f;
      bit [63:0]   run_sum, k;
      int unsigned n, keep, goal, children, cnt, i;
      picks.delete();
      f = longint'($signed(w.fitness));
      // words past the store depth are dropped, but a closing one still counts
      if (n_loaded < MAX_POP) begin
         if (f < lowest) begin
            // new minimum: rebase everything already summed
            total += 64'(n_loaded) * 64'(lowest - f);
            lowest = f;
         end
         total += 64'(f - lowest);
         fit_mem[n_loaded] = w.fitness;
         n_loaded++;
      end
      if (!w.last_item) return;

      n = n_loaded;
      keep = (cfg_keep < n) ? cfg_keep : n;
      for (i = 0; i < keep; i++)
         picks.push_back('{kind: KIND_PRESERVED, parent_index: idx_field_type'(i),
                           last_result: 1'b0});
      goal = (cfg_target > MAX_POP) ? MAX_POP : cfg_target;
      children = (goal > keep) ? goal - keep : 0;
      if (children > 0 && cfg_share != 0) begin
         k = 1;
         run_sum = '0;
         cnt = 0;
         // pointer k sits at total*k*share/(256*children); compare exactly by cross-multiplying
         for (i = 0; i < n && cnt < children; i++) begin
            run_sum += 64'(longint'($signed(fit_mem[i])) - lowest);
            while (cnt < children &&
                   total * k * 64'(cfg_share) <= run_sum * 64'd256 * 64'(children)) begin
               picks.push_back('{kind: KIND_SAMPLED, parent_index: idx_field_type'(i),
                                 last_result: 1'b0});
               cnt++;
               k++;
            end
         end
      end
      if (picks.size() > 0) picks[picks.size()-1].last_result = 1'b1;
      n_loaded = 0;
      lowest = 0;
      total = '0;
   endfunction

   // ---------------------------------------------------------------------------
   // result side: stall pattern and checking
   // ---------------------------------------------------------------------------
   int mismatches = 0;
   int rx_cycle = 0;

   function automatic void note_mismatch(input string what, input rsp_type want,
                                         input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%s): expected kind %0d index %0d last %0d,",
                  what, want.kind, want.parent_index, want.last_result,
                  " got kind %0d index %0d last %0d",
                  got.kind, got.parent_index, got.last_result);
   endfunction

   function automatic void check_word(input rsp_type got);
      rsp_type want;
      if (expected_parents.size() == 0) begin
         note_mismatch("unexpected word", '0, got);
      end else begin
         want = expected_parents.pop_front();
         if (got.kind !== want.kind || got.parent_index !== want.parent_index ||
             got.last_result !== want.last_result)
            note_mismatch("wrong field", want, got);
      end
   endfunction

   // receiver cycles through full speed, coin flip and long stalls
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_word(rsp_data);
         rx_cycle++;
         case ((rx_cycle / 160) % 3)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            default: pop <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // watchdog
   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycles, expected_parents.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // load side and register writes
   // ---------------------------------------------------------------------------
   int burst_left = 0;

   // sender works in bursts; push stays high across back-to-back words
   task automatic send_word(input req_type w, input bit model_checked);
      if (burst_left == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (full) @(posedge clock);
      load_word(w);
      if (model_checked)
         foreach (picks[i]) expected_parents.push_back(picks[i]);
   endtask

   // block idle: every parent out, then room for a walk that emits nothing
   task automatic drain();
      push <= 1'b0;
      burst_left = 0;
      while (expected_parents.size() != 0) @(posedge clock);
      repeat (WALK_LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!ready) @(posedge clock);
      case (index)
         CSR_POPULATION_TARGET: cfg_target = data[TARGET_W-1:0];
         CSR_PRESERVED_COUNT:   cfg_keep = data[PRESERVE_W-1:0];
         CSR_BEST_SHARE:        cfg_share = data[SHARE_W-1:0];
         default: ;
      endcase
   endtask

   // raw 9-bit data on purpose: the 7-bit registers drop the upper bits
   task automatic set_config(input logic [CSR_DATA_W-1:0] target_raw,
                             input logic [CSR_DATA_W-1:0] keep_raw,
                             input logic [CSR_DATA_W-1:0] share_raw);
      drain();
      write_reg(CSR_POPULATION_TARGET, target_raw);
      write_reg(CSR_PRESERVED_COUNT, keep_raw);
      write_reg(CSR_BEST_SHARE, share_raw);
      valid <= 1'b0;
   endtask

   function automatic int random_fitness(input int mode);
      if ($urandom_range(0, 15) == 0)
         return ($urandom_range(0, 1) == 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      case (mode)
         0: return int'($urandom_range(0, 2**21)) - 2**20;   // small, around zero
         1: return int'($urandom_range(0, 100 * 65536));     // 0.0 .. 100.0
         default: return int'($urandom());                   // whole range
      endcase
   endfunction

   // one generation, best first unless it is a noise generation
   task automatic send_generation(input int len, input bit sorted, input int mode);
      int      vals[$];
      req_type w;
      int      i;
      for (i = 0; i < len; i++) vals.push_back(random_fitness(mode));
      if (sorted) vals.rsort();
      for (i = 0; i < len; i++) begin
         w.fitness = vals[i];
         // noise: an early closing word splits the generation
         w.last_item = (i == len - 1) || (!sorted && $urandom_range(0, 9) == 0);
         send_word(w, 1'b1);
      end
   endtask

   // ---------------------------------------------------------------------------
   // directed steps
   // ---------------------------------------------------------------------------
   typedef struct {
      bit                      new_cfg;
      logic [CSR_DATA_W-1:0]   target_raw;
      logic [CSR_DATA_W-1:0]   keep_raw;
      logic [CSR_DATA_W-1:0]   share_raw;
      logic signed [FIT_W-1:0] fitness;
      bit                      last;
      bit                      typed;       // expectation written out below
      int                      typed_n;
      logic                    typed_kind;
      int                      typed_first;
      int                      typed_step;
   } step_row_type;

   step_row_type directed_steps [N_DIRECTED];

   initial begin
      req_type w;
      int      r, j, gen, len, random_words;
      bit      big_done;

      directed_steps = '{
         // after reset: single zero word, zero total puts every child on index 0
         '{0, 0, 0, 0, 0, 1, 1, 64, KIND_SAMPLED, 0, 0},
         // extremes: lowest drops to the minimum and the sum is rebased
         '{0, 0, 0, 0, 32'sh7FFFFFFF, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 32'sh80000000, 1, 0, 0, 0, 0, 0},
         // more preserved than loaded, and target not above it: no children
         '{1, 3, 5, 256, 100 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 50 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 10 * 65536, 1, 1, 3, KIND_PRESERVED, 0, 1},
         // target above store depth, zero share: nothing comes out at all
         '{1, 127, 0, 0, 5 * 65536, 1, 1, 0, 0, 0, 0},
         // share above 256: the walk runs off the end with slots unfilled
         '{1, 10, 2, 511, 300 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 200 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 100 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
         // small share, negative tail
         '{1, 8, 1, 26, 40 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 20 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, -3 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, -10 * 65536, 1, 0, 0, 0, 0, 0},
         // upper data bits ignored by the 7-bit registers: target 1, none kept
         '{1, 9'h181, 9'h100, 256, -7 * 65536, 1, 1, 1, KIND_SAMPLED, 0, 0},
         // keep everything loaded, the rest are children
         '{1, 64, 64, 256, 9 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 8 * 65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 7 * 65536, 1, 0, 0, 0, 0, 0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < N_DIRECTED; r++) begin
         if (directed_steps[r].new_cfg)
            set_config(directed_steps[r].target_raw, directed_steps[r].keep_raw,
                       directed_steps[r].share_raw);
         w.fitness = directed_steps[r].fitness;
         w.last_item = directed_steps[r].last;
         send_word(w, !directed_steps[r].typed);
         if (directed_steps[r].typed)
            for (j = 0; j < directed_steps[r].typed_n; j++)
               expected_parents.push_back('{
                  kind: directed_steps[r].typed_kind,
                  parent_index: idx_field_type'(directed_steps[r].typed_first +
                                                j * directed_steps[r].typed_step),
                  last_result: (j == directed_steps[r].typed_n - 1)});
      end

      // random generations; one oversized load overflows the store
      gen = 0;
      random_words = 0;
      big_done = 1'b0;
      while (random_words < RANDOM_WORDS) begin
         if (gen % 3 == 0 || $urandom_range(0, 3) == 0)
            set_config(CSR_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                               : $urandom_range(1, 64)),
                       CSR_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                               : $urandom_range(0, 6)),
                       CSR_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                               : $urandom_range(26, 256)));
         if (gen == 1 && !big_done) begin
            big_done = 1'b1;
            len = MAX_POP + int'($urandom_range(1, 4));
            send_generation(len, 1'b1, 2);
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                              : $urandom_range(1, 10);
            send_generation(len, $urandom_range(0, 4) != 0, $urandom_range(0, 2));
         end
         random_words += len;
         gen++;
      end

      // wait out the last results and any walk still running
      drain();
      if (mismatches == 0 && expected_parents.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
